// ===== rtl/bldc_pkg.sv =====
// shared types, constants and commutation tables for the hall six-step commutator
`default_nettype none
package bldc_pkg;

  localparam int LEVEL_BITS_DEF    = 12;
  localparam int ROTATION_BITS_DEF = 32;

  typedef logic [2:0] sector_t;
  typedef logic [1:0] phase_t;

  typedef enum logic {
    CMD_HALL_EDGE = 1'b0,
    CMD_SET_LEVEL = 1'b1
  } cmd_t;

  localparam phase_t PHASE_U = 2'd0;
  localparam phase_t PHASE_V = 2'd1;
  localparam phase_t PHASE_W = 2'd2;

  // hall decode result handed to the top level
  typedef struct packed {
    logic             code_ok;
    sector_t          sector;
    logic signed [2:0] step;
  } hall_dec_t;

  // hall code 1..6 to sector, invalid codes map to 0
  function automatic sector_t code_to_sector(input logic [2:0] code);
    sector_t s;
    unique case (code)
      3'd1:    s = 3'd0;
      3'd2:    s = 3'd2;
      3'd3:    s = 3'd1;
      3'd4:    s = 3'd4;
      3'd5:    s = 3'd5;
      3'd6:    s = 3'd3;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  function automatic sector_t fwd_order(input sector_t s);
    sector_t r;
    unique case (s)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd3;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic sector_t rev_order(input sector_t s);
    sector_t r;
    unique case (s)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd5;
      3'd2:    r = 3'd0;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd2;
      default: r = 3'd3;
    endcase
    return r;
  endfunction

  function automatic phase_t float_phase(input sector_t row);
    phase_t p;
    unique case (row)
      3'd0:    p = PHASE_W;
      3'd1:    p = PHASE_U;
      3'd2:    p = PHASE_V;
      3'd3:    p = PHASE_W;
      3'd4:    p = PHASE_U;
      default: p = PHASE_V;
    endcase
    return p;
  endfunction

  function automatic phase_t drv_phase(input sector_t row);
    phase_t p;
    unique case (row)
      3'd0:    p = PHASE_U;
      3'd1:    p = PHASE_W;
      3'd2:    p = PHASE_W;
      3'd3:    p = PHASE_V;
      3'd4:    p = PHASE_V;
      default: p = PHASE_U;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bldc_hall_decode.sv =====
// hall code decode and wrapped sector step
`default_nettype none
module bldc_hall_decode (
  input  wire logic [2:0]          hall_bits,
  input  wire bldc_pkg::sector_t   prev_sector,
  output bldc_pkg::hall_dec_t      dec
);
  import bldc_pkg::*;

  sector_t           sector;
  logic signed [3:0] delta;
  logic signed [3:0] wrapped;

  always_comb begin
    sector = code_to_sector(hall_bits);
    delta  = $signed({1'b0, sector}) - $signed({1'b0, prev_sector});
    // changes of three or more go the short way round
    priority if (delta <= -4'sd3) begin
      wrapped = delta + 4'sd6;
    end else if (delta >= 4'sd3) begin
      wrapped = delta - 4'sd6;
    end else begin
      wrapped = delta;
    end
    dec.code_ok = (hall_bits != 3'd0) && (hall_bits != 3'd7);
    dec.sector  = sector;
    dec.step    = wrapped[2:0];
  end

endmodule
`default_nettype wire

// ===== rtl/bldc_commutate.sv =====
// commutation table lookup: phase enables and compare values for one drive level
`default_nettype none
module bldc_commutate #(
  parameter int LEVEL_BITS = bldc_pkg::LEVEL_BITS_DEF
) (
  input  wire logic signed [LEVEL_BITS-1:0] level,
  input  wire bldc_pkg::sector_t            sector,
  output logic [LEVEL_BITS-2:0]             cmp_u,
  output logic [LEVEL_BITS-2:0]             cmp_v,
  output logic [LEVEL_BITS-2:0]             cmp_w,
  output logic [2:0]                        enable,
  output logic                              stopped
);
  import bldc_pkg::*;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MIN = {1'b1, {(LEVEL_BITS-1){1'b0}}};

  logic [LEVEL_BITS-1:0] neg;
  logic [LEVEL_BITS-2:0] mag;
  sector_t               row;
  phase_t                fl;
  phase_t                dr;

  always_comb begin
    neg = -level;
    if (!level[LEVEL_BITS-1]) begin
      mag = level[LEVEL_BITS-2:0];
    end else if (level == LEVEL_MIN) begin
      mag = {(LEVEL_BITS-1){1'b1}};
    end else begin
      mag = neg[LEVEL_BITS-2:0];
    end
    row     = level[LEVEL_BITS-1] ? rev_order(sector) : fwd_order(sector);
    fl      = float_phase(row);
    dr      = drv_phase(row);
    stopped = (level == '0);
    if (stopped) begin
      enable = 3'b000;
      cmp_u  = '0;
      cmp_v  = '0;
      cmp_w  = '0;
    end else begin
      enable = 3'b111 & ~(3'b001 << fl);
      cmp_u  = (dr == PHASE_U) ? mag : '0;
      cmp_v  = (dr == PHASE_V) ? mag : '0;
      cmp_w  = (dr == PHASE_W) ? mag : '0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bldc_hall_six_step_commutator.sv =====
// a word accepted passes two registers: the input register, then the result register
// throughput: one word per cycle; in_ready stays high while the result register can move on
// the result register can hold a finished word while the next one waits in the input register
// reset (rst, synchronous): both registers empty, sector 0, rotation 0, drive level 0,
// all phases floating and the stopped flag set so the first drive level commutes at once
`default_nettype none
module bldc_hall_six_step_commutator #(
  parameter int LEVEL_BITS    = bldc_pkg::LEVEL_BITS_DEF,
  parameter int ROTATION_BITS = bldc_pkg::ROTATION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            command,
  input  wire logic [2:0]                      hall_bits,
  input  wire logic signed [LEVEL_BITS-1:0]    pwm_request,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [LEVEL_BITS-2:0]                compare_u,
  output logic [LEVEL_BITS-2:0]                compare_v,
  output logic [LEVEL_BITS-2:0]                compare_w,
  output logic                                 enable_u,
  output logic                                 enable_v,
  output logic                                 enable_w,
  output logic [2:0]                           sector_out,
  output logic signed [ROTATION_BITS-1:0]      rotation_count,
  output logic                                 hall_fault
);
  import bldc_pkg::*;

  // input register
  logic                          in_full;
  cmd_t                          cmd_q;
  logic [2:0]                    hall_q;
  logic signed [LEVEL_BITS-1:0]  level_q;

  // commutator state
  sector_t                       sector;
  logic [ROTATION_BITS-1:0]      rotation;
  logic signed [LEVEL_BITS-1:0]  drive_level;
  logic                          stopped;
  logic [LEVEL_BITS-2:0]         cmp_u, cmp_v, cmp_w;
  logic [2:0]                    enable;

  // next state
  sector_t                       sector_next;
  logic [ROTATION_BITS-1:0]      rotation_next;
  logic signed [LEVEL_BITS-1:0]  drive_level_next;
  logic                          stopped_next;
  logic [LEVEL_BITS-2:0]         cmp_u_next, cmp_v_next, cmp_w_next;
  logic [2:0]                    enable_next;
  logic                          fault_next;

  // datapath results
  hall_dec_t                     dec;
  logic signed [LEVEL_BITS-1:0]  level_use;
  logic [LEVEL_BITS-2:0]         drv_u, drv_v, drv_w;
  logic [2:0]                    drv_en;
  logic                          drv_stop;
  logic                          needs_hall;
  logic                          do_commute;
  logic                          store_level;
  logic                          advance;

  // the word in the input register moves on whenever the result register is free or drained
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  bldc_hall_decode u_decode (
    .hall_bits   (hall_q),
    .prev_sector (sector),
    .dec         (dec)
  );

  // a new level drives the table directly, a hall edge uses the stored level
  assign level_use = (cmd_q == CMD_SET_LEVEL) ? level_q : drive_level;

  bldc_commutate #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_commutate (
    .level   (level_use),
    .sector  (dec.sector),
    .cmp_u   (drv_u),
    .cmp_v   (drv_v),
    .cmp_w   (drv_w),
    .enable  (drv_en),
    .stopped (drv_stop)
  );

  always_comb begin
    // a level change while running only stores the level and skips the hall pins
    needs_hall  = (cmd_q == CMD_HALL_EDGE) || stopped;
    do_commute  = needs_hall && dec.code_ok;
    fault_next  = needs_hall && !dec.code_ok;
    store_level = (cmd_q == CMD_SET_LEVEL) && (!stopped || dec.code_ok);

    sector_next      = sector;
    rotation_next    = rotation;
    stopped_next     = stopped;
    cmp_u_next       = cmp_u;
    cmp_v_next       = cmp_v;
    cmp_w_next       = cmp_w;
    enable_next      = enable;
    drive_level_next = store_level ? level_q : drive_level;
    if (do_commute) begin
      sector_next   = dec.sector;
      rotation_next = rotation + {{(ROTATION_BITS-3){dec.step[2]}}, dec.step};
      stopped_next  = drv_stop;
      cmp_u_next    = drv_u;
      cmp_v_next    = drv_v;
      cmp_w_next    = drv_w;
      enable_next   = drv_en;
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q   <= cmd_t'(command);
      hall_q  <= hall_bits;
      level_q <= pwm_request;
    end
  end

  // commutator state
  always_ff @(posedge clk) begin
    if (rst) begin
      sector      <= '0;
      rotation    <= '0;
      drive_level <= '0;
      stopped     <= 1'b1;
      cmp_u       <= '0;
      cmp_v       <= '0;
      cmp_w       <= '0;
      enable      <= 3'b000;
    end else if (advance) begin
      sector      <= sector_next;
      rotation    <= rotation_next;
      drive_level <= drive_level_next;
      stopped     <= stopped_next;
      cmp_u       <= cmp_u_next;
      cmp_v       <= cmp_v_next;
      cmp_w       <= cmp_w_next;
      enable      <= enable_next;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload, a snapshot of the state after the word
  always_ff @(posedge clk) begin
    if (advance) begin
      compare_u      <= cmp_u_next;
      compare_v      <= cmp_v_next;
      compare_w      <= cmp_w_next;
      enable_u       <= enable_next[0];
      enable_v       <= enable_next[1];
      enable_w       <= enable_next[2];
      sector_out     <= sector_next;
      rotation_count <= rotation_next;
      hall_fault     <= fault_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bldc_checker.sv =====
// port-level checks for the hall six-step commutator and their bind
`default_nettype none
module bldc_checker #(
  parameter int LEVEL_BITS    = bldc_pkg::LEVEL_BITS_DEF,
  parameter int ROTATION_BITS = bldc_pkg::ROTATION_BITS_DEF
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [LEVEL_BITS-2:0]        compare_u,
  input wire logic [LEVEL_BITS-2:0]        compare_v,
  input wire logic [LEVEL_BITS-2:0]        compare_w,
  input wire logic                         enable_u,
  input wire logic                         enable_v,
  input wire logic                         enable_w,
  input wire logic [2:0]                   sector_out,
  input wire logic [ROTATION_BITS-1:0]     rotation_count,
  input wire logic                         hall_fault
);

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rotation_count) && $stable(sector_out)
      && $stable(hall_fault))
    else $error("result word changed while stalled");

  // either all phases float or exactly one floats
  a_enable_pattern: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones({enable_u, enable_v, enable_w}) == 0)
      || ($countones({enable_u, enable_v, enable_w}) == 2))
    else $error("illegal phase enable pattern");

  // a floating phase never carries a compare value, and at most one phase is driven
  a_compare_floating: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (enable_u || compare_u == '0) && (enable_v || compare_v == '0)
      && (enable_w || compare_w == '0)
      && $countones({compare_u != '0, compare_v != '0, compare_w != '0}) <= 1)
    else $error("compare value on a floating phase or on two phases");

  // sector stays in range
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_out <= 3'd5)
    else $error("sector out of range");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bldc_hall_six_step_commutator bldc_checker #(
  .LEVEL_BITS    (LEVEL_BITS),
  .ROTATION_BITS (ROTATION_BITS)
) u_bldc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .compare_u      (compare_u),
  .compare_v      (compare_v),
  .compare_w      (compare_w),
  .enable_u       (enable_u),
  .enable_v       (enable_v),
  .enable_w       (enable_w),
  .sector_out     (sector_out),
  .rotation_count (rotation_count),
  .hall_fault     (hall_fault)
);
`default_nettype wire
